### rtl/hwt_pkg.sv
// Shared types, widths and codes for the hashed timing wheel.
`timescale 1ns / 1ps

package hwt_pkg;

    // Sizing of the wheel and the timer pool
    localparam int MAX_SLOTS    = 64;
    localparam int POOL_ENTRIES = 32;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SIZE_W = SLOT_W + 1;
    localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W  = IDX_W + 1;

    localparam logic [CNT_W-1:0] POOL_END = CNT_W'(POOL_ENTRIES);

    // Fixed field widths
    localparam int WSIZE_W  = 7;
    localparam int TICK_W   = 16;
    localparam int DELAY_W  = 24;
    localparam int HANDLE_W = 16;
    localparam int ROUNDS_W = 24;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Shared divider: one quotient bit per cycle
    localparam int DIV_W  = 24;
    localparam int ITER_W = $clog2(DIV_W + 1);

    // Opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADD_OK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN   = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [DELAY_W-1:0]  delay_ms;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] expired_handle;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [DIV_W-1:0]  dividend;
        logic [TICK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [TICK_W-1:0] rem;
    } div_rsp_t;

endpackage

### rtl/hwt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module hwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hwt_div.sv
// Restoring divider, one quotient bit per cycle, shared by the add and tick arithmetic.
`timescale 1ns / 1ps

module hwt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hwt_pkg::div_req_t req,
    output hwt_pkg::div_rsp_t rsp
);

    import hwt_pkg::*;

    logic [ITER_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  acc_reg;     // dividend shifts out, quotient shifts in
    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] dsr_reg;

    logic [TICK_W:0] trial;
    logic [TICK_W:0] diff;
    logic            ge;

    always_comb
    begin
        trial = {rem_reg, acc_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.iters;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - ITER_W'(1);
            done_reg <= (cnt_reg == ITER_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= {acc_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/hashed_timing_wheel.sv
// Top level of the single-level hashed timing wheel with a bounded timer pool.
`timescale 1ns / 1ps

// Channel   Signals                         Direction  Transfer when
// cmd       cmd_valid, cmd_stall, cmd       in         cmd_valid && !cmd_stall
// rsp       rsp_valid, rsp_stall, rsp       out        rsp_valid && !rsp_stall
// cfg       cfg_we, cfg_index, cfg_data     in         cfg_we
//
// One command is worked on at a time; cmd_stall is high from acceptance until
// the command's final result sits in the output register.
// Add: slot mod size, delay / tick length and (ticks-1) / size, each on the
// one-bit-per-cycle divider; the free-entry search runs alongside and only
// lengthens the add when it outlasts the divisions. A full pool rejects early.
// Tick: slot mod size, then a scan with one read of the pool RAM per cycle;
// rsp_stall pauses the scan when a second expiry waits. Reset clears the
// valid bits at once; there is no clearing pass.

module hashed_timing_wheel (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  hwt_pkg::cmd_t                         cmd,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output hwt_pkg::rsp_t                         rsp,
    input  logic                                  cfg_we,
    input  logic [hwt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hwt_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import hwt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_ADD_MOD   = 8'b0000_0010,   // current slot mod wheel size
        S_ADD_DIV   = 8'b0000_0100,   // delay / tick length
        S_ADD_RND   = 8'b0000_1000,   // (ticks-1) / wheel size
        S_ADD_FIN   = 8'b0001_0000,   // store entry, report
        S_TICK_MOD  = 8'b0010_0000,
        S_TICK_SCAN = 8'b0100_0000,   // walk the pool, one entry per cycle unless a held expiry blocks
        S_TICK_END  = 8'b1000_0000    // final result, advance pointer
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [WSIZE_W-1:0] wheel_size_reg;
    logic [TICK_W-1:0]  tick_len_reg;

    // Wheel and pool control
    logic [SLOT_W-1:0]       current_slot_reg;
    logic [POOL_ENTRIES-1:0] valid_reg;

    // Per-command working registers
    cmd_t                cmd_reg;
    logic [SLOT_W-1:0]   cur_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ROUNDS_W-1:0] rounds_reg;

    // Free-entry search
    logic [CNT_W-1:0] search_idx_reg;
    logic             search_done_reg;
    logic             search_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Tick scan
    logic [CNT_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                chk_valid_reg;
    logic                pend_valid_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;

    // Output register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Shared divider and pool RAM
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    // Derived values
    logic                accept;
    logic                out_free;
    logic [SIZE_W-1:0]   eff_size;
    logic [TICK_W-1:0]   tl_eff;
    logic [DELAY_W-1:0]  delay_eff;
    logic [DIV_W-1:0]    ticks_m1;
    logic [SIZE_W-1:0]   slot_sum;
    logic [SIZE_W-1:0]   slot_fix;
    logic [SIZE_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   slot_adv_val;
    logic                scan_more;
    logic                reject;
    logic                hit;
    logic                expire;
    logic                block;

    // Control strobes from the sequencer
    logic out_load;
    rsp_t out_next;
    logic valid_set;
    logic valid_clr;
    logic cur_load;
    logic rnd_load;
    logic scan_start;
    logic scan_adv;
    logic pend_take;
    logic slot_adv;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rd_entry  = entry_t'(ram_rdata);
    assign scan_more = (scan_idx_reg != POOL_END);
    assign reject    = search_done_reg && !search_found_reg;

    // Wheel size 0 acts as 1, sizes above MAX_SLOTS saturate
    always_comb
    begin
        if (wheel_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(wheel_size_reg) > 32'(MAX_SLOTS))
        begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = SIZE_W'(wheel_size_reg);
        end
    end

    always_comb
    begin
        tl_eff    = (tick_len_reg == '0) ? TICK_W'(1) : tick_len_reg;
        delay_eff = (cmd_reg.delay_ms == '0) ? DELAY_W'(tl_eff) : cmd_reg.delay_ms;
        // ticks has a floor of one, so ticks-1 floors at zero
        ticks_m1  = (div_rsp.quot == '0) ? '0 : div_rsp.quot - DIV_W'(1);
        // slot = (cur + (ticks-1) mod size) mod size, with cur already below size
        slot_sum  = {1'b0, cur_reg} + {1'b0, div_rsp.rem[SLOT_W-1:0]};
        slot_fix  = (slot_sum >= eff_size) ? slot_sum - eff_size : slot_sum;
        slot_inc  = {1'b0, cur_reg} + SIZE_W'(1);
        slot_adv_val = (slot_inc == eff_size) ? '0 : slot_inc[SLOT_W-1:0];
    end

    // Scan compare on the entry whose RAM read has returned
    always_comb
    begin
        hit    = chk_valid_reg && valid_reg[chk_idx_reg] && (rd_entry.slot == cur_reg);
        expire = hit && (rd_entry.rounds == '0);
        // a second expiry must first push the held one out
        block  = expire && pend_valid_reg && !out_free;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;

        div_req.start    = 1'b0;
        div_req.iters    = ITER_W'(SLOT_W);
        div_req.dividend = {current_slot_reg, {(DIV_W-SLOT_W){1'b0}}};
        div_req.divisor  = TICK_W'(eff_size);

        ram_we           = 1'b0;
        ram_waddr        = chk_idx_reg;
        ram_wdata.slot   = rd_entry.slot;
        ram_wdata.rounds = rd_entry.rounds - ROUNDS_W'(1);
        ram_wdata.handle = rd_entry.handle;
        ram_re           = 1'b0;
        ram_raddr        = scan_idx_reg[IDX_W-1:0];

        out_load                = 1'b0;
        out_next.kind           = KIND_NONE;
        out_next.expired_handle = '0;
        out_next.last           = 1'b1;

        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        cur_load   = 1'b0;
        rnd_load   = 1'b0;
        scan_start = 1'b0;
        scan_adv   = 1'b0;
        pend_take  = 1'b0;
        slot_adv   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // both commands begin with current slot mod size
                    div_req.start = 1'b1;
                    state_next = (cmd.opcode == OP_ADD) ? S_ADD_MOD : S_TICK_MOD;
                end
            end
            S_ADD_MOD:
            begin
                if (reject)
                begin
                    state_next = S_ADD_FIN;
                end
                else if (div_rsp.done)
                begin
                    cur_load         = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(DIV_W);
                    div_req.dividend = DIV_W'(delay_eff);
                    div_req.divisor  = tl_eff;
                    state_next       = S_ADD_DIV;
                end
            end
            S_ADD_DIV:
            begin
                if (reject)
                begin
                    state_next = S_ADD_FIN;
                end
                else if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(DIV_W);
                    div_req.dividend = ticks_m1;
                    state_next       = S_ADD_RND;
                end
            end
            S_ADD_RND:
            begin
                if (reject)
                begin
                    state_next = S_ADD_FIN;
                end
                else if (div_rsp.done)
                begin
                    rnd_load   = 1'b1;
                    state_next = S_ADD_FIN;
                end
            end
            S_ADD_FIN:
            begin
                if (search_done_reg && out_free)
                begin
                    out_load = 1'b1;
                    if (search_found_reg)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = free_idx_reg;
                        ram_wdata.slot   = slot_reg;
                        ram_wdata.rounds = rounds_reg;
                        ram_wdata.handle = cmd_reg.handle;
                        valid_set        = 1'b1;
                        out_next.kind    = KIND_ADD_OK;
                    end
                    else
                    begin
                        out_next.kind = KIND_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK_MOD:
            begin
                if (div_rsp.done)
                begin
                    cur_load   = 1'b1;
                    scan_start = 1'b1;
                    state_next = S_TICK_SCAN;
                end
            end
            S_TICK_SCAN:
            begin
                if (!block)
                begin
                    scan_adv = 1'b1;
                    if (expire)
                    begin
                        valid_clr = 1'b1;
                        pend_take = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_load                = 1'b1;
                            out_next.kind           = KIND_EXPIRED;
                            out_next.expired_handle = pend_handle_reg;
                            out_next.last           = 1'b0;
                        end
                    end
                    else if (hit)
                    begin
                        ram_we = 1'b1;   // one round less
                    end
                    if (scan_more)
                    begin
                        ram_re = 1'b1;
                    end
                    else if (!chk_valid_reg)
                    begin
                        state_next = S_TICK_END;
                    end
                end
            end
            S_TICK_END:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    slot_adv = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next.kind           = KIND_EXPIRED;
                        out_next.expired_handle = pend_handle_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wheel_size_reg   <= WSIZE_W'(8);
            tick_len_reg     <= TICK_W'(1000);
            current_slot_reg <= '0;
            valid_reg        <= '0;
            search_idx_reg   <= '0;
            search_done_reg  <= 1'b1;
            search_found_reg <= 1'b0;
            scan_idx_reg     <= '0;
            chk_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WHEEL_SIZE: wheel_size_reg <= cfg_data[WSIZE_W-1:0];
                    CFG_TICK_LEN:   tick_len_reg   <= cfg_data[TICK_W-1:0];
                    default:        ;
                endcase
            end

            if (slot_adv)
            begin
                current_slot_reg <= slot_adv_val;
            end

            if (valid_set)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end

            // lowest free entry, one pool entry per cycle
            if (accept)
            begin
                search_idx_reg   <= '0;
                search_done_reg  <= 1'b0;
                search_found_reg <= 1'b0;
            end
            else if (!search_done_reg)
            begin
                if (search_idx_reg == POOL_END)
                begin
                    search_done_reg <= 1'b1;
                end
                else if (!valid_reg[search_idx_reg[IDX_W-1:0]])
                begin
                    search_done_reg  <= 1'b1;
                    search_found_reg <= 1'b1;
                end
                else
                begin
                    search_idx_reg <= search_idx_reg + CNT_W'(1);
                end
            end

            if (scan_start)
            begin
                scan_idx_reg   <= '0;
                chk_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else if (scan_adv)
            begin
                chk_valid_reg <= scan_more;
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (pend_take)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end

            rsp_valid_reg <= out_load || (rsp_valid_reg && rsp_stall);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (cur_load)
        begin
            cur_reg <= div_rsp.rem[SLOT_W-1:0];
        end
        if (rnd_load)
        begin
            rounds_reg <= div_rsp.quot;
            slot_reg   <= slot_fix[SLOT_W-1:0];
        end
        if (!search_done_reg && (search_idx_reg != POOL_END))
        begin
            free_idx_reg <= search_idx_reg[IDX_W-1:0];
        end
        if (scan_adv && scan_more)
        begin
            chk_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (pend_take)
        begin
            pend_handle_reg <= rd_entry.handle;
        end
        if (out_load)
        begin
            rsp_reg <= out_next;
        end
    end

    hwt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_ENTRIES)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### test/wheel_checker.sv
// Checker for the hashed timing wheel: tracks the timer pool and compares every result.
`timescale 1ns / 1ps

module wheel_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_stall,
    input  hwt_pkg::cmd_t                  cmd,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  hwt_pkg::rsp_t                  rsp,
    input  logic                           cfg_we,
    input  logic [hwt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hwt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             items_done,
    output int                             live_timers,
    output int                             pending
);
    import hwt_pkg::*;

    // Shadow configuration and wheel state
    logic [WSIZE_W-1:0]  wheel_size;
    logic [TICK_W-1:0]   tick_len;
    logic [SLOT_W-1:0]   now_slot;
    logic                timer_used   [POOL_ENTRIES];
    logic [SLOT_W-1:0]   timer_slot   [POOL_ENTRIES];
    logic [ROUNDS_W-1:0] timer_rounds [POOL_ENTRIES];
    logic [HANDLE_W-1:0] timer_handle [POOL_ENTRIES];

    rsp_t due_results[$];
    int   mismatches;
    int   finished;

    function automatic int unsigned slots_in_use();
        int unsigned s;
        s = wheel_size;
        if (s == 0) s = 1;
        if (s > MAX_SLOTS) s = MAX_SLOTS;
        return s;
    endfunction

    // append one predicted result at the tail of the queue
    function automatic void queue_result(input rsp_t r);
        due_results = {due_results, r};
    endfunction

    task automatic schedule_timer(input cmd_t c);
        int unsigned size;
        int unsigned cur;
        int unsigned tl;
        int unsigned ticks;
        int          free_at;
        rsp_t        r;
        size    = slots_in_use();
        cur     = now_slot % size;
        tl      = (tick_len == 0) ? 1 : tick_len;
        free_at = -1;
        // lowest free entry wins
        for (int i = POOL_ENTRIES - 1; i >= 0; i--)
            if (!timer_used[i]) free_at = i;
        r      = '0;
        r.last = 1'b1;
        if (free_at < 0) begin
            r.kind = KIND_FULL;
        end else begin
            ticks = (c.delay_ms == 0) ? tl : c.delay_ms;
            ticks = ticks / tl;
            if (ticks == 0) ticks = 1;
            timer_used[free_at]   = 1'b1;
            timer_slot[free_at]   = SLOT_W'((cur + ticks - 1) % size);
            timer_rounds[free_at] = ROUNDS_W'((ticks - 1) / size);
            timer_handle[free_at] = c.handle;
            r.kind = KIND_ADD_OK;
        end
        queue_result(r);
    endtask

    task automatic advance_wheel();
        int unsigned size;
        int unsigned cur;
        bit          held_any;
        rsp_t        held;
        size     = slots_in_use();
        cur      = now_slot % size;
        held_any = 1'b0;
        held     = '0;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (timer_used[i] && timer_slot[i] == cur) begin
                if (timer_rounds[i] == 0) begin
                    // previous expiry is not the final one
                    if (held_any) queue_result(held);
                    timer_used[i]       = 1'b0;
                    held.kind           = KIND_EXPIRED;
                    held.expired_handle = timer_handle[i];
                    held.last           = 1'b0;
                    held_any            = 1'b1;
                end else begin
                    timer_rounds[i] = timer_rounds[i] - 1'b1;
                end
            end
        end
        now_slot = SLOT_W'((cur + 1) % size);
        if (held_any) begin
            held.last = 1'b1;
        end else begin
            held.kind           = KIND_NONE;
            held.expired_handle = '0;
            held.last           = 1'b1;
        end
        queue_result(held);
    endtask

    always @(posedge clk or negedge rst_n) begin
        int   live;
        rsp_t want;
        if (!rst_n) begin
            wheel_size = WSIZE_W'(8);
            tick_len   = TICK_W'(1000);
            now_slot   = '0;
            for (int i = 0; i < POOL_ENTRIES; i++) timer_used[i] = 1'b0;
            due_results.delete();
            mismatches = 0;
            finished   = 0;
            fail_count  <= 0;
            items_done  <= 0;
            live_timers <= 0;
            pending     <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WHEEL_SIZE) wheel_size = cfg_data[WSIZE_W-1:0];
                else                             tick_len   = cfg_data;
            end

            if (cmd_valid && !cmd_stall) begin
                if (cmd.opcode == OP_ADD) schedule_timer(cmd);
                else                      advance_wheel();
                live = 0;
                for (int i = 0; i < POOL_ENTRIES; i++) live += timer_used[i];
                live_timers <= live;
            end

            if (rsp_valid && !rsp_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected: kind %0d handle %h last %b",
                             $time, rsp.kind, rsp.expired_handle, rsp.last);
                end else begin
                    want = due_results.pop_front();
                    if (rsp.kind !== want.kind) begin
                        mismatches++;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, rsp.kind);
                    end
                    if (rsp.expired_handle !== want.expired_handle) begin
                        mismatches++;
                        $display("%0t: expired_handle expected %h actual %h",
                                 $time, want.expired_handle, rsp.expired_handle);
                    end
                    if (rsp.last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, rsp.last);
                    end
                    if (want.last) finished++;
                end
            end

            fail_count <= mismatches;
            items_done <= finished;
            pending    <= due_results.size();
        end
    end

endmodule

### test/testbench.sv
// Top of the timing wheel test: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
    import hwt_pkg::*;

    // Safety net; a run that reaches this limit fails.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 6;
    // Drains need at most about 26 ticks; this only bounds a stuck pool.
    localparam int DRAIN_MAX   = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_t                  cmd       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WHEEL_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int items_done;
    int live_timers;
    int pending;

    int sent    = 0;      // commands transferred so far
    int cycles  = 0;
    bit no_idle = 1'b0;   // phases that run both channels flat out
    int hold    = 0;      // remaining stall cycles on the result channel

    // One configuration setting plus the shape of its random traffic
    typedef struct {
        logic [CFG_DATA_W-1:0] size_word;
        logic [CFG_DATA_W-1:0] tick_word;
        int                    items;
        int                    add_pct;
        bit                    wide;     // full-range delays
        bit                    quiet;    // no idling on either side
        bit                    drain;    // empty the pool before moving on
    } phase_t;

    hashed_timing_wheel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wheel_checker check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .items_done  (items_done),
        .live_timers (live_timers),
        .pending     (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: after each transfer, draw how long to hold off the next one.
    // The stall may also land while a tick scan is between expiries.
    always @(posedge clk) begin
        if (rsp_valid && !rsp_stall) begin
            hold = no_idle ? 0 : $urandom_range(0, 6);
            rsp_stall <= (hold != 0);
        end else if (hold != 0) begin
            hold = hold - 1;
            rsp_stall <= (hold != 0);
        end
    end

    // Settings walked in order: size 1 / tick 1, zero for both (read as 1),
    // oversize wheel (saturates), a size word with junk above bit 6, a shrink
    // while timers are still live, then both maxima with wide delays.
    function automatic phase_t phase_plan(input int p);
        phase_t ph;
        ph = '{16'd1, 16'd1, 18, 60, 1'b0, 1'b0, 1'b1};
        case (p)
            1: ph = '{16'd0,    16'd0,    18, 55, 1'b0, 1'b1, 1'b1};
            2: ph = '{16'd127,  16'd7,    20, 65, 1'b0, 1'b0, 1'b1};
            3: ph = '{16'hFF85, 16'd300,  18, 65, 1'b0, 1'b0, 1'b0};
            4: ph = '{16'd3,    16'd300,  14, 50, 1'b0, 1'b0, 1'b0};
            5: ph = '{16'd64,   16'hFFFF, 22, 95, 1'b1, 1'b0, 1'b0};
            default: ;
        endcase
        return ph;
    endfunction

    function automatic cmd_t make_cmd(input logic op, input logic [DELAY_W-1:0] d,
                                      input logic [HANDLE_W-1:0] h);
        cmd_t c;
        c.opcode   = op;
        c.delay_ms = d;
        c.handle   = h;
        return c;
    endfunction

    // Mostly delays up to three laps and a tick out (at most 25 ticks) so timers fire;
    // some zeros, and in wide phases full 24-bit values.
    function automatic logic [DELAY_W-1:0] pick_delay(input int unsigned sz,
                                                      input int unsigned tl,
                                                      input bit wide);
        int unsigned r;
        int unsigned t;
        int unsigned d;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (wide && r < 6) return DELAY_W'($urandom_range(0, 24'hFFFFFF));
        t = $urandom_range(0, (3 * sz + 1 > 25) ? 25 : 3 * sz + 1);
        d = t * tl + $urandom_range(0, tl - 1);
        if (d > 24'hFFFFFF) d = 24'hFFFFFF;
        return DELAY_W'(d);
    endfunction

    // Valid is only lowered when an idle gap is drawn, so back-to-back
    // commands never see valid dropped and raised in the same step.
    task automatic send(input cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sent++;
    endtask

    task automatic wait_results();
        cmd_valid <= 1'b0;
        while (items_done != sent) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] size_word,
                              input logic [CFG_DATA_W-1:0] tick_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WHEEL_SIZE;
        cfg_data  <= size_word;
        @(posedge clk);
        cfg_index <= CFG_TICK_LEN;
        cfg_data  <= tick_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Tick until every timer has fired, so a new wheel size strands nothing.
    task automatic drain();
        int n;
        n = 0;
        while (live_timers != 0 && n < DRAIN_MAX) begin
            send(make_cmd(OP_TICK, DELAY_W'($urandom), HANDLE_W'($urandom)));
            wait_results();
            n++;
        end
    endtask

    initial begin
        phase_t      plan;
        int unsigned sz;
        int unsigned tl;
        logic        op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default config (8 slots, 1000 ms):
        // zero delay, sub-tick delay, exact tick, remainder, last slot, second lap.
        send(make_cmd(OP_ADD, 24'd0,    16'hFFFF));
        send(make_cmd(OP_ADD, 24'd999,  16'h0000));
        send(make_cmd(OP_ADD, 24'd1000, 16'h0001));
        send(make_cmd(OP_ADD, 24'd1500, 16'h0002));
        send(make_cmd(OP_ADD, 24'd8000, 16'h0003));
        send(make_cmd(OP_ADD, 24'd9000, 16'h0004));
        // first tick fires four timers in pool order; then empty slots,
        // the slot-7 timer, and the lapped one on slot 0
        repeat (10) send(make_cmd(OP_TICK, 24'd0, 16'h0000));
        wait_results();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            plan = phase_plan(p);
            wait_results();
            repeat (8) @(posedge clk);
            write_regs(plan.size_word, plan.tick_word);
            no_idle <= plan.quiet;

            sz = plan.size_word[WSIZE_W-1:0];
            if (sz == 0) sz = 1;
            if (sz > MAX_SLOTS) sz = MAX_SLOTS;
            tl = (plan.tick_word == 0) ? 1 : plan.tick_word;

            if (p == 5) begin
                // longest delay, and one just under a tick at the longest tick length
                send(make_cmd(OP_ADD, 24'hFFFFFF, 16'h5A5A));
                send(make_cmd(OP_ADD, 24'd65534,  16'hA5A5));
            end

            for (int i = 0; i < plan.items; i++) begin
                op = ($urandom_range(0, 99) < plan.add_pct) ? OP_ADD : OP_TICK;
                send(make_cmd(op, pick_delay(sz, tl, plan.wide),
                              HANDLE_W'($urandom_range(0, 16'hFFFF))));
            end

            if (plan.drain) begin
                wait_results();
                drain();
            end
        end

        wait_results();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
